// ===== hw/rtl/robst_pkg.sv =====
// Shared types and constants for the ray / oriented box slab test.
// No dependencies; every other file of the block but robst_if imports this package.
`default_nettype none

package robst_pkg;

    // Field widths
    localparam int W_VAL     = 40;  // Q23.16 coordinates and distances
    localparam int W_UNIT    = 18;  // Q1.16 unit vector components
    localparam int W_EPS     = 17;  // parallel threshold
    localparam int W_FAR     = 39;  // far limit register
    localparam int W_CFG_IDX = 3;
    localparam int W_DIFF    = W_VAL + 1;            // center - origin
    localparam int W_PE      = W_DIFF + W_UNIT;      // one product of e
    localparam int W_PF      = 2 * W_UNIT;           // one product of f
    localparam int W_E32     = W_PE + 2;             // sum of three, Q.32
    localparam int W_F32     = W_PF + 2;
    localparam int W_E       = W_E32 - 16;           // e at Q.16
    localparam int W_F       = W_F32 - 16;           // f at Q.16
    localparam int W_NUM     = W_E + 1;              // e + slab bound
    localparam int W_QUO     = W_VAL;                // quotient bits kept

    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers
    localparam logic signed [W_UNIT-1:0] DIR_X_RST     = 18'sd65536;
    localparam logic        [W_EPS-1:0]  EPS_RST       = 17'd66;
    localparam logic        [W_FAR-1:0]  FAR_LIMIT_RST = 39'd6553600000;

    // Saturation bounds of a distance
    localparam logic signed [W_VAL-1:0] S40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [W_VAL-1:0] S40_MIN = 40'sh80_0000_0000;

    // Configuration register map
    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_DIR_X     = 3'd3,
        CFG_DIR_Y     = 3'd4,
        CFG_DIR_Z     = 3'd5,
        CFG_EPS       = 3'd6,
        CFG_FAR_LIMIT = 3'd7
    } t_cfg_idx;

    // Ray registers seen by the front end
    typedef struct packed {
        logic signed [W_VAL-1:0]  origin_x;
        logic signed [W_VAL-1:0]  origin_y;
        logic signed [W_VAL-1:0]  origin_z;
        logic signed [W_UNIT-1:0] dir_x;
        logic signed [W_UNIT-1:0] dir_y;
        logic signed [W_UNIT-1:0] dir_z;
        logic        [W_EPS-1:0]  eps;
    } t_ray_cfg;

    // One classified slab, handed from front to back
    typedef struct packed {
        logic                    parallel;
        logic                    last;
        logic signed [W_NUM-1:0] num_lo;
        logic signed [W_NUM-1:0] num_hi;
        logic signed [W_F-1:0]   f;
    } t_slab_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START1,
        B_WAIT1,
        B_START2,
        B_WAIT2,
        B_UPD,
        B_OUT
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/robst_if.sv =====
// Handshake channels of the slab test: slab beats in, box results out.
// Standalone; widths match those of robst_pkg.
`default_nettype none

interface robst_slab_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] axis_x;
    logic signed [17:0] axis_y;
    logic signed [17:0] axis_z;
    logic signed [39:0] center_x;
    logic signed [39:0] center_y;
    logic signed [39:0] center_z;
    logic signed [39:0] slab_low;
    logic signed [39:0] slab_high;
    logic               last_slab;

    modport source (
        output valid, axis_x, axis_y, axis_z, center_x, center_y, center_z,
               slab_low, slab_high, last_slab,
        input  ready
    );
    modport sink (
        input  valid, axis_x, axis_y, axis_z, center_x, center_y, center_z,
               slab_low, slab_high, last_slab,
        output ready
    );
endinterface

interface robst_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [39:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/robst_front.sv =====
// Front end: accepts slab beats, forms e and f, classifies the slab.
// Depends on robst_pkg and robst_slab_if.
`default_nettype none

module robst_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  robst_pkg::t_ray_cfg    i_cfg,
    robst_slab_if.sink             i_slab,
    output logic                   o_push,
    output robst_pkg::t_slab_job   o_job,
    input  wire                    i_full
);
    import robst_pkg::*;

    t_front_state r_state, n_state;

    // latched slab
    logic signed [W_UNIT-1:0] r_ax, r_ay, r_az;
    logic signed [W_VAL-1:0]  r_cx, r_cy, r_cz, r_lo, r_hi;
    logic                     r_last;

    // registered products
    logic signed [W_PE-1:0] r_pex, r_pey, r_pez;
    logic signed [W_PF-1:0] r_pfx, r_pfy, r_pfz;

    logic                      accept;
    logic signed [W_DIFF-1:0]  dx, dy, dz;
    logic signed [W_E32-1:0]   e32;
    logic signed [W_F32-1:0]   f32;
    logic signed [W_E-1:0]     e;
    logic signed [W_F-1:0]     f;
    logic        [W_F-1:0]     fabs;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_slab.valid) n_state = F_MUL;
            F_MUL:   n_state = F_SUM;
            F_SUM:   if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_slab.ready = 1'b0;
        o_push       = 1'b0;
        unique case (r_state)
            F_IDLE:  i_slab.ready = 1'b1;
            F_MUL:   ;
            F_SUM:   o_push = !i_full;
            default: ;
        endcase
    end

    assign accept = i_slab.valid && i_slab.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax   <= i_slab.axis_x;
            r_ay   <= i_slab.axis_y;
            r_az   <= i_slab.axis_z;
            r_cx   <= i_slab.center_x;
            r_cy   <= i_slab.center_y;
            r_cz   <= i_slab.center_z;
            r_lo   <= i_slab.slab_low;
            r_hi   <= i_slab.slab_high;
            r_last <= i_slab.last_slab;
        end
    end

    // dot product terms, exact at Q.32
    always_comb begin
        dx = W_DIFF'(r_cx) - W_DIFF'(i_cfg.origin_x);
        dy = W_DIFF'(r_cy) - W_DIFF'(i_cfg.origin_y);
        dz = W_DIFF'(r_cz) - W_DIFF'(i_cfg.origin_z);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_MUL) begin
            r_pex <= W_PE'(dx) * W_PE'(r_ax);
            r_pey <= W_PE'(dy) * W_PE'(r_ay);
            r_pez <= W_PE'(dz) * W_PE'(r_az);
            r_pfx <= W_PF'(r_ax) * W_PF'(i_cfg.dir_x);
            r_pfy <= W_PF'(r_ay) * W_PF'(i_cfg.dir_y);
            r_pfz <= W_PF'(r_az) * W_PF'(i_cfg.dir_z);
        end
    end

    // sums, floor to Q.16 and classification
    always_comb begin
        e32  = W_E32'(r_pex) + W_E32'(r_pey) + W_E32'(r_pez);
        f32  = W_F32'(r_pfx) + W_F32'(r_pfy) + W_F32'(r_pfz);
        e    = e32[W_E32-1:16];
        f    = f32[W_F32-1:16];
        fabs = f[W_F-1] ? W_F'(-f) : W_F'(f);

        o_job.parallel = !(fabs > W_F'(i_cfg.eps));
        o_job.last     = r_last;
        o_job.num_lo   = W_NUM'(e) + W_NUM'(r_lo);
        o_job.num_hi   = W_NUM'(e) + W_NUM'(r_hi);
        o_job.f        = f;
    end

`ifndef SYNTHESIS
    a_push_only_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == F_SUM) && !i_full)
        else $error("push outside sum step");
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == F_MUL))
        else $error("accepted beat not multiplied");
    a_sum_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_MUL) |=> (r_state == F_SUM))
        else $error("multiply step not followed by sum");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/robst_queue.sv =====
// Short queue of classified slabs between front and back.
// Depends on robst_pkg.
`default_nettype none

module robst_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  robst_pkg::t_slab_job  i_job,
    output logic                  o_full,
    input  wire                   i_pop,
    output robst_pkg::t_slab_job  o_job,
    output logic                  o_empty
);
    import robst_pkg::*;

    localparam int W_PTR = $clog2(QUEUE_DEPTH);
    localparam int W_CNT = $clog2(QUEUE_DEPTH + 1);

    t_slab_job         r_mem [QUEUE_DEPTH];
    logic [W_PTR-1:0]  r_wr, r_rd;
    logic [W_CNT-1:0]  r_cnt;

    assign o_full  = (r_cnt == W_CNT'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == W_PTR'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == W_PTR'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= W_CNT'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/robst_div.sv =====
// Iterative signed divider: sat40((num << 16) / f), truncating toward zero,
// two quotient bits a cycle. Depends on robst_pkg.
`default_nettype none

module robst_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire signed [robst_pkg::W_NUM-1:0]  i_num,
    input  wire signed [robst_pkg::W_F-1:0]    i_f,
    output logic                               o_busy,
    output logic                               o_done,
    output logic signed [robst_pkg::W_VAL-1:0] o_quo
);
    import robst_pkg::*;

    localparam int STEPS  = W_QUO / 2;
    localparam int W_STEP = $clog2(STEPS);

    logic                    r_busy, r_done, r_neg;
    logic [W_STEP-1:0]       r_cnt;
    logic [W_F-1:0]          r_d, r_rem;
    logic [W_QUO-1:0]        r_dvd, r_q;
    logic signed [W_VAL-1:0] r_quo;

    logic [W_NUM-1:0] nmag;
    logic [W_F-1:0]   fmag;
    logic             ovf;
    logic [W_F:0]     t1, t2;
    logic             b1, b2;
    logic [W_F-1:0]   rem1, rem2;
    logic [W_QUO-1:0] q_fin;
    logic signed [W_VAL-1:0] quo_fin;

    // operand magnitudes; the dividend is nmag followed by 16 zero bits
    always_comb begin
        nmag = i_num[W_NUM-1] ? W_NUM'(-i_num) : W_NUM'(i_num);
        fmag = i_f[W_F-1] ? W_F'(-i_f) : W_F'(i_f);
        ovf  = nmag[W_NUM-1 -: W_F] >= fmag;  // quotient needs more than 40 bits
    end

    // two restoring steps
    always_comb begin
        t1   = {r_rem, r_dvd[W_QUO-1]};
        b1   = t1 >= {1'b0, r_d};
        rem1 = b1 ? W_F'(t1 - {1'b0, r_d}) : W_F'(t1);
        t2   = {rem1, r_dvd[W_QUO-2]};
        b2   = t2 >= {1'b0, r_d};
        rem2 = b2 ? W_F'(t2 - {1'b0, r_d}) : W_F'(t2);
        q_fin = {r_q[W_QUO-3:0], b1, b2};
        if (r_neg) begin
            quo_fin = (q_fin > W_QUO'(S40_MIN)) ? S40_MIN : -$signed(q_fin);
        end else begin
            quo_fin = q_fin[W_QUO-1] ? S40_MAX : $signed(q_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !ovf;
                r_done <= ovf;
            end else if (r_busy && r_cnt == W_STEP'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[W_NUM-1] ^ i_f[W_F-1];
            r_d   <= fmag;
            r_rem <= nmag[W_NUM-1 -: W_F];
            r_dvd <= {nmag[W_NUM-W_F-1:0], 16'd0};
            r_q   <= '0;
            r_cnt <= '0;
            r_quo <= (i_num[W_NUM-1] ^ i_f[W_F-1]) ? S40_MIN : S40_MAX;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_dvd <= {r_dvd[W_QUO-3:0], 2'b00};
            r_q   <= q_fin;
            r_cnt <= r_cnt + 1'b1;
            r_quo <= quo_fin;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held more than one cycle");
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_d)
        else $error("partial remainder not reduced");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/robst_back.sv =====
// Back end: pops classified slabs, runs the divisions, keeps the running
// interval and delivers one result beat per box. Depends on robst_pkg,
// robst_div and robst_res_if.
`default_nettype none

module robst_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire         [robst_pkg::W_FAR-1:0] i_far_limit,
    input  robst_pkg::t_slab_job               i_job,
    input  wire                                i_empty,
    output logic                               o_pop,
    robst_res_if.source                        o_res
);
    import robst_pkg::*;

    t_back_state r_state, n_state;

    t_slab_job               r_job;
    logic signed [W_VAL-1:0] r_t_lo;
    logic signed [W_VAL-1:0] r_near, r_far;
    logic                    r_missed;
    logic                    r_out_valid, r_out_hit;
    logic signed [W_VAL-1:0] r_out_dist;

    logic                    div_start, div_busy, div_done;
    logic signed [W_NUM-1:0] div_num;
    logic signed [W_VAL-1:0] div_quo;
    logic                    out_free, out_load;
    logic signed [W_VAL-1:0] t1, t2, far_n, near_n;

    assign out_free = !r_out_valid || o_res.ready;
    assign div_num  = (r_state == B_START1) ? r_job.num_lo : r_job.num_hi;

    robst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_f     (r_job.f),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = (r_missed || i_job.parallel) ? B_UPD : B_START1;
                end
            end
            B_START1: n_state = B_WAIT1;
            B_WAIT1:  if (div_done) n_state = B_START2;
            B_START2: n_state = B_WAIT2;
            B_WAIT2:  if (div_done) n_state = B_UPD;
            B_UPD:    n_state = r_job.last ? B_OUT : B_IDLE;
            B_OUT:    if (out_free) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            B_IDLE:   o_pop = !i_empty;
            B_START1: div_start = 1'b1;
            B_WAIT1:  ;
            B_START2: div_start = 1'b1;
            B_WAIT2:  ;
            B_UPD:    ;
            B_OUT:    out_load = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_state == B_WAIT1 && div_done) r_t_lo <= div_quo;
    end

    // interval update: entry/exit ordered, then intersected
    always_comb begin
        if (r_t_lo > div_quo) begin
            t1 = div_quo;
            t2 = r_t_lo;
        end else begin
            t1 = r_t_lo;
            t2 = div_quo;
        end
        far_n  = (t2 < r_far) ? t2 : r_far;
        near_n = (t1 > r_near) ? t1 : r_near;
    end

    // box state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= '0;
            r_far    <= W_VAL'(FAR_LIMIT_RST);
            r_missed <= 1'b0;
        end else if (out_load) begin
            r_near   <= '0;
            r_far    <= W_VAL'(i_far_limit);
            r_missed <= 1'b0;
        end else if (r_state == B_UPD && !r_missed) begin
            if (r_job.parallel) begin
                if (r_job.num_lo > 0 || r_job.num_hi < 0) r_missed <= 1'b1;
            end else begin
                r_near <= near_n;
                r_far  <= far_n;
                if (far_n < near_n) r_missed <= 1'b1;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= !r_missed;
            r_out_dist <= r_missed ? '0 : r_near;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.hit      = r_out_hit;
    assign o_res.distance = r_out_dist;

`ifndef SYNTHESIS
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("division started while divider busy");
    a_load_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && !r_missed && r_near == '0)
        else $error("box end did not post result and reset state");
    a_miss_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_dist == '0)
        else $error("miss with nonzero distance");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == B_IDLE)
        else $error("pop while busy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ray_oriented_box_slab_test.sv =====
// Top level of the ray / oriented box slab test: configuration registers,
// front end, slab queue and back end. Depends on robst_pkg and robst_if.
//
// Each slab beat passes the front-end steps capture, multiply and sum,
// then waits in a two-entry queue for the back end. In the back end each
// division takes a start step and then waits on the shared radix-4
// divider, which skips the iteration when the quotient saturates at once. A slab
// that needs the interval update therefore passes through the pop step,
// two divisions and the update step. A parallel slab, or any slab after the
// box has missed, takes only the pop and update steps.
// The divider therefore limits the sustained slab rate.
// The last slab of a box adds an output step to post the result beat, which is
// held in an output register so the next box can start while it waits.
`default_nettype none

module ray_oriented_box_slab_test (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [robst_pkg::W_CFG_IDX-1:0]         i_cfg_idx,
    input  wire [robst_pkg::W_VAL-1:0]             i_cfg_data,
    robst_slab_if.sink                             i_slab,
    robst_res_if.source                            o_res
);
    import robst_pkg::*;

    t_ray_cfg          r_cfg;
    logic [W_FAR-1:0]  r_far_limit;

    logic              push, pop, full, empty;
    t_slab_job         job_in, job_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.origin_z <= '0;
            r_cfg.dir_x    <= DIR_X_RST;
            r_cfg.dir_y    <= '0;
            r_cfg.dir_z    <= '0;
            r_cfg.eps      <= EPS_RST;
            r_far_limit    <= FAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:  r_cfg.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y:  r_cfg.origin_y <= i_cfg_data;
                CFG_ORIGIN_Z:  r_cfg.origin_z <= i_cfg_data;
                CFG_DIR_X:     r_cfg.dir_x    <= i_cfg_data[W_UNIT-1:0];
                CFG_DIR_Y:     r_cfg.dir_y    <= i_cfg_data[W_UNIT-1:0];
                CFG_DIR_Z:     r_cfg.dir_z    <= i_cfg_data[W_UNIT-1:0];
                CFG_EPS:       r_cfg.eps      <= i_cfg_data[W_EPS-1:0];
                CFG_FAR_LIMIT: r_far_limit    <= i_cfg_data[W_FAR-1:0];
                default:       ;
            endcase
        end
    end

    robst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_slab  (i_slab),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    robst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    robst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_far_limit (r_far_limit),
        .i_job       (job_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== sim/ray_oriented_box_slab_test_tb.sv =====
// Testbench for ray_oriented_box_slab_test: directed slab table, then random boxes.
// Checks every result beat against a built-in predictor of the slab test.
// Depends on robst_pkg, robst_if and the block's top level.
`timescale 1ns / 1ps

module ray_oriented_box_slab_test_tb;
    import robst_pkg::*;

    typedef struct {
        logic signed [17:0] ax, ay, az;
        logic signed [39:0] cx, cy, cz, lo, hi;
        logic               last;
        logic               chk;   // typed-in expectation present
        logic               ehit;
        logic signed [39:0] edist;
    } t_slab_row;

    typedef struct {
        logic               hit;
        logic signed [39:0] distance;
    } t_box_res;

    localparam longint S40MX = 64'sd549755813887;
    localparam longint S40MN = -64'sd549755813888;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [39:0] i_cfg_data = '0;

    robst_slab_if slab_ch ();
    robst_res_if  res_ch ();

    ray_oriented_box_slab_test dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_slab    (slab_ch.sink),
        .o_res     (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: ray registers and running box interval
    longint org_x, org_y, org_z, dir_x, dir_y, dir_z, eps_q, far_lim;
    longint near_d, far_d;
    bit     box_missed;

    t_box_res expected_boxes[$];
    int       errors = 0;
    longint   cycles = 0;
    int       send_idle = 0, recv_idle = 0;

    function automatic longint floor_q16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint sat_div(longint num, longint f);
        longint q;
        q = (num * 65536) / f;
        if (q > S40MX) return S40MX;
        if (q < S40MN) return S40MN;
        return q;
    endfunction

    function automatic void start_box();
        near_d = 0;
        far_d = far_lim;
        box_missed = 1'b0;
    endfunction

    // Apply one slab to the running interval; push a result on the last slab
    function automatic void predict_slab(t_slab_row s);
        longint e, f, fa, t1, t2, t;
        t_box_res r;
        if (!box_missed) begin
            e = floor_q16(longint'(s.ax) * (longint'(s.cx) - org_x)
                        + longint'(s.ay) * (longint'(s.cy) - org_y)
                        + longint'(s.az) * (longint'(s.cz) - org_z));
            f = floor_q16(longint'(s.ax) * dir_x + longint'(s.ay) * dir_y
                        + longint'(s.az) * dir_z);
            fa = f < 0 ? -f : f;
            if (fa > eps_q) begin
                t1 = sat_div(e + s.lo, f);
                t2 = sat_div(e + s.hi, f);
                if (t1 > t2) begin
                    t = t1; t1 = t2; t2 = t;
                end
                if (t2 < far_d) far_d = t2;
                if (t1 > near_d) near_d = t1;
                if (far_d < near_d) box_missed = 1'b1;
            end else if (e + s.lo > 0 || e + s.hi < 0) begin
                box_missed = 1'b1;
            end
        end
        if (s.last) begin
            r.hit = !box_missed;
            r.distance = box_missed ? 40'sd0 : near_d[39:0];
            expected_boxes.push_back(r);
            start_box();
        end
    endfunction

    // Register write, mirrored into the predictor
    task automatic write_reg(t_cfg_idx idx, logic [39:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:  org_x = longint'($signed(val));
            CFG_ORIGIN_Y:  org_y = longint'($signed(val));
            CFG_ORIGIN_Z:  org_z = longint'($signed(val));
            CFG_DIR_X:     dir_x = longint'($signed(val[17:0]));
            CFG_DIR_Y:     dir_y = longint'($signed(val[17:0]));
            CFG_DIR_Z:     dir_z = longint'($signed(val[17:0]));
            CFG_EPS:       eps_q = longint'(val[16:0]);
            CFG_FAR_LIMIT: far_lim = longint'(val[38:0]);
            default: ;
        endcase
    endtask

    // Drain results, then let the back end settle before a register write
    task automatic wait_idle();
        while (expected_boxes.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // One beat: valid was dropped at the previous falling edge, so raise it
    // at a later one
    task automatic send_slab(t_slab_row s);
        @(negedge i_clk);
        while (send_idle != 0 && $urandom_range(99) < send_idle) @(negedge i_clk);
        slab_ch.valid <= 1'b1;
        slab_ch.axis_x <= s.ax;
        slab_ch.axis_y <= s.ay;
        slab_ch.axis_z <= s.az;
        slab_ch.center_x <= s.cx;
        slab_ch.center_y <= s.cy;
        slab_ch.center_z <= s.cz;
        slab_ch.slab_low <= s.lo;
        slab_ch.slab_high <= s.hi;
        slab_ch.last_slab <= s.last;
        @(posedge i_clk);
        while (!slab_ch.ready) @(posedge i_clk);
        predict_slab(s);
        @(negedge i_clk);
        slab_ch.valid <= 1'b0;
    endtask

    function automatic t_slab_row mk(longint ax, longint ay, longint az, longint cx,
                                     longint cy, longint cz, longint lo, longint hi,
                                     bit last);
        t_slab_row s;
        s.ax = 18'(ax); s.ay = 18'(ay); s.az = 18'(az);
        s.cx = 40'(cx); s.cy = 40'(cy); s.cz = 40'(cz);
        s.lo = 40'(lo); s.hi = 40'(hi); s.last = last;
        s.chk = 1'b0; s.ehit = 1'b0; s.edist = '0;
        return s;
    endfunction

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(255)), $urandom()};
    endfunction

    function automatic longint rand_small(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Random axis: mostly a unit principal axis, else bounded random components or raw bits
    function automatic t_slab_row rand_slab(bit last);
        t_slab_row s;
        int k;
        k = $urandom_range(9);
        s = mk(0, 0, 0, 0, 0, 0, 0, 0, last);
        if (k < 6) begin
            case ($urandom_range(2))
                0: s.ax = $urandom_range(1) ? 18'sd65536 : -18'sd65536;
                1: s.ay = $urandom_range(1) ? 18'sd65536 : -18'sd65536;
                default: s.az = $urandom_range(1) ? 18'sd65536 : -18'sd65536;
            endcase
        end else if (k < 8) begin
            s.ax = 18'(rand_small(46341));
            s.ay = 18'(rand_small(46341));
            s.az = 18'(rand_small(46341));
        end else begin
            s.ax = 18'($urandom()); s.ay = 18'($urandom()); s.az = 18'($urandom());
        end
        if ($urandom_range(9) < 8) begin
            s.cx = 40'(rand_small(40) * 65536 + rand_small(65535));
            s.cy = 40'(rand_small(40) * 65536 + rand_small(65535));
            s.cz = 40'(rand_small(40) * 65536 + rand_small(65535));
            s.lo = 40'(-longint'($urandom_range(10 * 65536)));
            s.hi = 40'(longint'($urandom_range(10 * 65536)));
            if ($urandom_range(15) == 0) begin
                s.lo = s.hi; s.hi = 40'(-longint'($urandom_range(65536)));
            end
        end else begin
            s.cx = rand40(); s.cy = rand40(); s.cz = rand40();
            s.lo = rand40(); s.hi = rand40();
        end
        return s;
    endfunction

    // Result side: random stall, compare with the oldest expectation
    always @(negedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        t_box_res want;
        cycles <= cycles + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_boxes.size() == 0) begin
                $error("result beat with nothing expected: hit=%0b distance=%0d",
                       res_ch.hit, res_ch.distance);
                errors++;
            end else begin
                want = expected_boxes.pop_front();
                if (res_ch.hit !== want.hit) begin
                    $error("hit: expected %0b actual %0b", want.hit, res_ch.hit);
                    errors++;
                end
                if (res_ch.distance !== want.distance) begin
                    $error("distance: expected %0d actual %0d", want.distance,
                           res_ch.distance);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_oriented_box_slab_test: mismatch");
            $finish;
        end
    end

    t_slab_row dir_tab[$];

    initial begin
        t_slab_row s;
        t_box_res got;
        int nboxes, nsl;
        slab_ch.valid = 1'b0;
        slab_ch.axis_x = '0; slab_ch.axis_y = '0; slab_ch.axis_z = '0;
        slab_ch.center_x = '0; slab_ch.center_y = '0; slab_ch.center_z = '0;
        slab_ch.slab_low = '0; slab_ch.slab_high = '0; slab_ch.last_slab = 1'b0;
        org_x = 0; org_y = 0; org_z = 0;
        dir_x = 65536; dir_y = 0; dir_z = 0;
        eps_q = 66; far_lim = 64'd6553600000;
        start_box();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed expectations only where obvious from reset state
        s = mk(65536, 0, 0, 5 * 65536, 0, 0, -65536, 65536, 1);
        s.chk = 1'b1; s.ehit = 1'b1; s.edist = 40'(4 * 65536);
        dir_tab.push_back(s);                                               // x slab hit
        s = mk(0, 65536, 0, 0, 0, 0, -65536, 65536, 1);
        s.chk = 1'b1; s.ehit = 1'b1; s.edist = '0; dir_tab.push_back(s);   // parallel, inside
        s = mk(0, 65536, 0, 0, 5 * 65536, 0, -65536, 65536, 1);
        s.chk = 1'b1; s.ehit = 1'b0; s.edist = '0; dir_tab.push_back(s);   // parallel, outside
        s = mk(-65536, 0, 0, 5 * 65536, 0, 0, -65536, 65536, 1);
        s.chk = 1'b1; s.ehit = 1'b1; s.edist = 40'(4 * 65536);
        dir_tab.push_back(s);                                               // swapped ends
        s = mk(65536, 0, 0, -5 * 65536, 0, 0, -65536, 65536, 1);
        s.chk = 1'b1; s.ehit = 1'b0; s.edist = '0; dir_tab.push_back(s);   // box behind
        // miss then ignored slabs, then a fresh box
        dir_tab.push_back(mk(0, 0, 65536, 0, 0, 9 * 65536, -65536, 65536, 0));
        dir_tab.push_back(mk(65536, 0, 0, 2 * 65536, 0, 0, -65536, 65536, 0));
        dir_tab.push_back(mk(65536, 0, 0, 3 * 65536, 0, 0, -65536, 65536, 1));
        // three-slab box
        dir_tab.push_back(mk(65536, 0, 0, 3 * 65536, 0, 0, -65536, 65536, 0));
        dir_tab.push_back(mk(0, 65536, 0, 0, 0, 0, -65536, 65536, 0));
        dir_tab.push_back(mk(0, 0, 65536, 0, 0, 0, -65536, 65536, 1));
        // field extremes, saturation, reversed extents, raw axis bits
        dir_tab.push_back(mk(131071, -131072, 131071, S40MX, S40MN, S40MX, S40MN, S40MX, 1));
        dir_tab.push_back(mk(-131072, 131071, -131072, S40MN, S40MX, S40MN, S40MX, S40MN, 1));
        dir_tab.push_back(mk(65536, 0, 0, S40MX, 0, 0, S40MX, S40MX, 1));
        dir_tab.push_back(mk(1, 0, 0, 65536, 0, 0, -65536, 65536, 1));
        dir_tab.push_back(mk(131071, 0, 0, 100, 0, 0, 65536, -65536, 1));
        dir_tab.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1));
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));

        foreach (dir_tab[i]) begin
            send_slab(dir_tab[i]);
            if (dir_tab[i].chk) begin
                got = expected_boxes[expected_boxes.size() - 1];
                if (got.hit !== dir_tab[i].ehit) begin
                    $error("directed row %0d hit: expected %0b actual %0b",
                           i, dir_tab[i].ehit, got.hit);
                    errors++;
                end
                if (got.distance !== dir_tab[i].edist) begin
                    $error("directed row %0d distance: expected %0d actual %0d",
                           i, dir_tab[i].edist, got.distance);
                    errors++;
                end
            end
        end
        wait_idle();

        // Random phases, each with its own ray setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin send_idle = 16; recv_idle = 68; end
                2: begin send_idle = 68; recv_idle = 16; end
                4: begin send_idle = 0;  recv_idle = 0;  end
                default: ;
            endcase
            case (ph)
                0: begin
                    write_reg(CFG_ORIGIN_X, 40'h80_0000_0000);
                    write_reg(CFG_ORIGIN_Y, 40'h7F_FFFF_FFFF);
                    write_reg(CFG_ORIGIN_Z, '0);
                    write_reg(CFG_EPS, 40'd0);
                    write_reg(CFG_FAR_LIMIT, 40'h7F_FFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_DIR_X, 40'h2_0000);
                    write_reg(CFG_DIR_Y, 40'h1_FFFF);
                    write_reg(CFG_DIR_Z, 40'h3_FFFF);
                    write_reg(CFG_EPS, 40'd65536);
                    write_reg(CFG_FAR_LIMIT, 40'd0);
                end
                default: begin
                    write_reg(CFG_ORIGIN_X, 40'(rand_small(20) * 65536));
                    write_reg(CFG_ORIGIN_Y, 40'(rand_small(20) * 65536));
                    write_reg(CFG_ORIGIN_Z, 40'(rand_small(20) * 65536));
                    write_reg(CFG_DIR_X, 40'(rand_small(65536)));
                    write_reg(CFG_DIR_Y, 40'(rand_small(65536)));
                    write_reg(CFG_DIR_Z, 40'(rand_small(65536)));
                    write_reg(CFG_EPS, 40'($urandom_range(200)));
                    write_reg(CFG_FAR_LIMIT, $urandom_range(1) ? 40'd6553600000
                                                               : 40'($urandom()));
                end
            endcase
            nboxes = 0;
            for (int n = 0; n < 92; ) begin
                nsl = $urandom_range(1, 3);
                for (int k = 0; k < nsl; k++) begin
                    send_slab(rand_slab(k == nsl - 1));
                    n++;
                end
                nboxes++;
                if (ph == 3 && nboxes == 5)
                    while (expected_boxes.size() != 0) @(negedge i_clk);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("ray_oriented_box_slab_test: match");
        else
            $display("ray_oriented_box_slab_test: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/robst_pkg.sv
hw/rtl/robst_if.sv
hw/rtl/robst_front.sv
hw/rtl/robst_queue.sv
hw/rtl/robst_div.sv
hw/rtl/robst_back.sv
hw/rtl/ray_oriented_box_slab_test.sv
sim/ray_oriented_box_slab_test_tb.sv
